[design/bfdh_pkg.sv]
// Package for the double-hash Bloom filter: shared constants, defaults and the
// sequencer state type. No dependencies.
package bfdh_pkg;

  // Default sizing of the filter.
  localparam int MAX_BITS_LOG2_DEF = 16;
  localparam int NUM_PROBES_DEF    = 8;

  // Size register: reset value and the smallest size in use (one word).
  localparam logic [4:0] SIZE_LOG2_RESET = 5'd16;
  localparam logic [4:0] MIN_SIZE_LOG2   = 5'd6;

  // Golden-ratio multiplier used to derive the second hash.
  localparam logic [63:0] GOLDEN = 64'h9e37_79b9_7f4a_7c15;

  // Action encoding: bit 0 selects query, bit 1 selects the 16-byte key.
  localparam int ACT_QUERY_BIT = 0;
  localparam int ACT_KEY_BIT   = 1;

  // Partial-product offsets inside the 128-bit accumulator.
  typedef enum logic [1:0] {
    OFF_0  = 2'd0,
    OFF_32 = 2'd1,
    OFF_64 = 2'd2
  } pp_off_t;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_MUL   = 5'b00100,
    S_PROBE = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

endpackage

[design/bloom_filter_double_hash.sv]
// Bloom filter with double hashing over a bit array held in a 64-bit-wide RAM.
// A hash item is hashed in one multiply pass and a key item in two (the key is folded to h1,
// then h2 is derived from it), on one shared 32x32 multiplier (4 partial products per 64x64
// product), with one RAM read per probe. One item is in work at a time: the next is accepted
// in the cycle after the result is loaded.
// Reset: a clearing pass zeroes all 2^(MAX_BITS_LOG2-6) RAM words while items are stalled.
module bloom_filter_double_hash #(
  parameter int MAX_BITS_LOG2 = bfdh_pkg::MAX_BITS_LOG2_DEF,
  parameter int NUM_PROBES    = bfdh_pkg::NUM_PROBES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  // Input item channel.
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  action,
  input  logic [63:0] word_lo,
  input  logic [63:0] word_hi,
  // Result channel.
  output logic        result_valid,
  input  logic        result_stall,
  output logic        hit
);

  // Word address width (at least one bit), position width and RAM depth.
  localparam int AW    = (MAX_BITS_LOG2 > 6) ? (MAX_BITS_LOG2 - 6) : 1;
  localparam int PW    = AW + 6;
  localparam int WORDS = 1 << AW;
  localparam int CW    = $clog2(NUM_PROBES + 1);

  bfdh_pkg::state_t state;

  // Configuration and operands.
  logic [4:0]    size_log2;
  logic          is_query;
  logic          pass_key;
  logic [63:0]   mx;
  logic [63:0]   my;

  // Shared multiplier and accumulator.
  logic [2:0]        step;
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [63:0]       prod;
  logic [63:0]       mul_q;
  bfdh_pkg::pp_off_t off_q;
  logic [127:0]      acc;
  logic [127:0]      addend;
  logic [127:0]      acc_sum;
  logic [63:0]       h1_key;
  logic [63:0]       gold_lo;
  logic [63:0]       h2_full;

  // Probe sequencing.
  logic [PW-1:0] pos;
  logic [PW-1:0] h2;
  logic [PW-1:0] mask;
  logic [PW-1:0] pos_masked;
  logic [4:0]    lg;
  logic [CW-1:0] issue_cnt;
  logic          issuing;
  logic          rs_valid;
  logic [5:0]    rs_bit;
  logic [AW-1:0] rs_addr;
  logic          all_set;
  logic          deliver;

  // Bit-array RAM and its write forwarding.
  logic [63:0]   mem [WORDS];
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] rd_addr;
  logic [63:0]   rd_q;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [63:0]   wr_data;
  logic          fwd_en;
  logic [AW-1:0] fwd_addr;
  logic [63:0]   fwd_data;
  logic [63:0]   word_eff;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != bfdh_pkg::S_IDLE);

  // Size register as written; clamping happens where the mask is formed.
  always_ff @(posedge clk) begin
    if (rst) begin
      size_log2 <= bfdh_pkg::SIZE_LOG2_RESET;
    end else if (cfg_valid && cfg_ready) begin
      size_log2 <= cfg_data;
    end
  end

  // Clamp the size to the supported range and build the position mask.
  always_comb begin
    if (size_log2 < bfdh_pkg::MIN_SIZE_LOG2) begin
      lg = bfdh_pkg::MIN_SIZE_LOG2;
    end else if (size_log2 > 5'(MAX_BITS_LOG2)) begin
      lg = 5'(MAX_BITS_LOG2);
    end else begin
      lg = size_log2;
    end
    for (int k = 0; k < PW; k++) begin
      mask[k] = (5'(k) < lg);
    end
  end

  assign pos_masked = pos & mask;

  // Partial-product operand selection for the shared multiplier.
  always_comb begin
    case (step[1:0])
      2'd0:    begin mul_a = mx[31:0];  mul_b = my[31:0];  end
      2'd1:    begin mul_a = mx[31:0];  mul_b = my[63:32]; end
      2'd2:    begin mul_a = mx[63:32]; mul_b = my[31:0];  end
      default: begin mul_a = mx[63:32]; mul_b = my[63:32]; end
    endcase
  end

  assign prod = {32'h0, mul_a} * {32'h0, mul_b};

  // Align the registered partial product and add it into the accumulator.
  always_comb begin
    case (off_q)
      bfdh_pkg::OFF_0:  addend = {64'h0, mul_q};
      bfdh_pkg::OFF_32: addend = {32'h0, mul_q, 32'h0};
      bfdh_pkg::OFF_64: addend = {mul_q, 64'h0};
      default:          addend = '0;
    endcase
  end

  assign acc_sum = acc + addend;
  assign h1_key  = acc_sum[63:0] ^ acc_sum[127:64];
  assign gold_lo = acc_sum[63:0];
  assign h2_full = (gold_lo ^ {32'h0, gold_lo[63:32]}) | 64'h1;

  // Probe issue: one RAM read per cycle until all probes are out.
  assign issuing = (state == bfdh_pkg::S_PROBE) && (issue_cnt != CW'(NUM_PROBES));
  assign rd_addr = pos_masked[PW-1:6];

  // The word written last cycle is newer than what the RAM returned.
  assign word_eff = (fwd_en && (fwd_addr == rs_addr)) ? fwd_data : rd_q;

  // RAM write: clearing pass, or read-modify-write of an insert probe.
  always_comb begin
    if (state == bfdh_pkg::S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else begin
      wr_en   = rs_valid && !is_query;
      wr_addr = rs_addr;
      wr_data = word_eff | (64'h1 << rs_bit);
    end
  end

  // Bit-array RAM with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // Forwarding copy of the last write.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_en <= 1'b0;
    end else begin
      fwd_en <= wr_en;
    end
    fwd_addr <= wr_addr;
    fwd_data <= wr_data;
  end

  // Probe resolve stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      rs_valid <= 1'b0;
    end else begin
      rs_valid <= issuing;
    end
    rs_bit  <= pos_masked[5:0];
    rs_addr <= rd_addr;
  end

  // The result is loaded once the output register is free or being emptied.
  assign deliver = (state == bfdh_pkg::S_FIN) && (!result_valid || !result_stall);

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (deliver) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bfdh_pkg::S_CLEAR;
      clr_addr  <= '0;
      step      <= '0;
      issue_cnt <= '0;
    end else begin
      unique case (state)
        bfdh_pkg::S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == {AW{1'b1}}) begin
            state <= bfdh_pkg::S_IDLE;
          end
        end
        bfdh_pkg::S_IDLE: begin
          if (item_valid) begin
            is_query <= action[bfdh_pkg::ACT_QUERY_BIT];
            pass_key <= action[bfdh_pkg::ACT_KEY_BIT];
            mx       <= word_lo;
            my       <= action[bfdh_pkg::ACT_KEY_BIT] ? word_hi : bfdh_pkg::GOLDEN;
            pos      <= word_lo[PW-1:0];
            acc      <= '0;
            step     <= '0;
            state    <= bfdh_pkg::S_MUL;
          end
        end
        bfdh_pkg::S_MUL: begin
          // Steps 0..3 multiply, steps 1..4 accumulate.
          if (step != 3'd4) begin
            mul_q <= prod;
            case (step[1:0])
              2'd0:    off_q <= bfdh_pkg::OFF_0;
              2'd3:    off_q <= bfdh_pkg::OFF_64;
              default: off_q <= bfdh_pkg::OFF_32;
            endcase
          end
          if (step == 3'd4) begin
            step <= '0;
            acc  <= '0;
            if (pass_key) begin
              // Key folded to h1; now derive h2 from it.
              pass_key <= 1'b0;
              mx       <= h1_key;
              my       <= bfdh_pkg::GOLDEN;
              pos      <= h1_key[PW-1:0];
            end else begin
              h2        <= h2_full[PW-1:0];
              issue_cnt <= '0;
              all_set   <= 1'b1;
              state     <= bfdh_pkg::S_PROBE;
            end
          end else begin
            step <= step + 3'd1;
            if (step != 3'd0) begin
              acc <= acc_sum;
            end
          end
        end
        bfdh_pkg::S_PROBE: begin
          if (issuing) begin
            pos       <= pos + h2;
            issue_cnt <= issue_cnt + 1'b1;
          end
          if (rs_valid) begin
            if (is_query && !word_eff[rs_bit]) begin
              all_set <= 1'b0;
            end
            if (!issuing) begin
              state <= bfdh_pkg::S_FIN;
            end
          end
        end
        bfdh_pkg::S_FIN: begin
          if (deliver) begin
            hit   <= is_query && all_set;
            state <= bfdh_pkg::S_IDLE;
          end
        end
        default: begin
          state <= bfdh_pkg::S_IDLE;
        end
      endcase
    end
  end

  // A probe resolves only while the sequencer is in the probe phase.
  a_resolve_in_probe: assert property (@(posedge clk) disable iff (rst)
    rs_valid |-> (state == bfdh_pkg::S_PROBE))
    else $error("probe resolve outside probe phase");

  // An accepted item always starts the multiply phase.
  a_accept_to_mul: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> (state == bfdh_pkg::S_MUL))
    else $error("accepted item did not start hashing");

  // A new result appears only out of the finish state.
  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == bfdh_pkg::S_FIN))
    else $error("result raised outside finish state");

  // The probe counter never runs past the probe count.
  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    (state == bfdh_pkg::S_PROBE) |-> (issue_cnt <= CW'(NUM_PROBES)))
    else $error("probe counter overran");

endmodule

[tb/tb.sv]
// Self-checking testbench for the double-hash Bloom filter (bloom_filter_double_hash).
// It predicts every hit from its own bit-array model and checks results in order.
// Depends on bfdh_pkg and the filter RTL.
`timescale 1ns / 1ps

module tb;

  localparam int MAX_LOG2      = bfdh_pkg::MAX_BITS_LOG2_DEF;
  localparam int PROBES        = bfdh_pkg::NUM_PROBES_DEF;
  localparam int WORDS         = (1 << MAX_LOG2) / 64;
  localparam int SETTLE_CYCLES = PROBES + 16;
  localparam int POOL_DEPTH    = 48;

  // Item actions as the block decodes them.
  typedef enum logic [1:0] {
    ACT_INS_HASH = 2'd0,
    ACT_QRY_HASH = 2'd1,
    ACT_INS_KEY  = 2'd2,
    ACT_QRY_KEY  = 2'd3
  } act_t;

  // One inserted item, kept so that it can be queried again later.
  typedef struct {
    act_t        act;
    logic [63:0] lo;
    logic [63:0] hi;
  } inserted_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [1:0]  action = '0;
  logic [63:0] word_lo = '0;
  logic [63:0] word_hi = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic        hit;

  // Shadow of the block's bit array and of its size register.
  logic [63:0] filter_words [0:WORDS-1];
  logic [4:0]  size_now = bfdh_pkg::SIZE_LOG2_RESET;

  logic        pending_hits [$];
  inserted_t   inserted_pool [$];
  int          error_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  bloom_filter_double_hash dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .action       (action),
    .word_lo      (word_lo),
    .word_hi      (word_hi),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .hit          (hit)
  );

  always #5 clk = ~clk;

  // Applies one item to the shadow filter and returns the hit it must give.
  function automatic logic predict_hit(input act_t act, input logic [63:0] lo,
                                       input logic [63:0] hi);
    logic [1:0]   code;
    logic [127:0] prod;
    logic [63:0]  h1;
    logic [63:0]  mix;
    logic [63:0]  step;
    logic [63:0]  pos;
    logic [63:0]  mask;
    logic [63:0]  p;
    int           lg;
    int           w;
    logic         all_set;
    code = act;
    prod = {64'd0, lo} * {64'd0, hi};
    h1 = code[bfdh_pkg::ACT_KEY_BIT] ? (prod[63:0] ^ prod[127:64]) : lo;
    mix = h1 * bfdh_pkg::GOLDEN;
    mix = mix ^ (mix >> 32);
    step = mix | 64'd1;
    lg = int'(size_now);
    if (lg < int'(bfdh_pkg::MIN_SIZE_LOG2)) lg = int'(bfdh_pkg::MIN_SIZE_LOG2);
    if (lg > MAX_LOG2) lg = MAX_LOG2;
    mask = (64'd1 << lg) - 64'd1;
    pos = h1;
    all_set = 1'b1;
    for (int i = 0; i < PROBES; i++) begin
      p = pos & mask;
      w = int'((p >> 6) & (WORDS - 1));
      if (code[bfdh_pkg::ACT_QUERY_BIT]) begin
        if (!filter_words[w][p[5:0]]) all_set = 1'b0;
      end else begin
        filter_words[w][p[5:0]] = 1'b1;
      end
      pos = pos + step;
    end
    return code[bfdh_pkg::ACT_QUERY_BIT] && all_set;
  endfunction

  // Random word, biased toward the extremes now and then.
  function automatic logic [63:0] rand_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Sends one item, with an optional idle gap first, and records its expected hit.
  task automatic send_item(input act_t act, input logic [63:0] lo, input logic [63:0] hi);
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = ($urandom_range(3) == 0) ? $urandom_range(5, 24) : $urandom_range(1, 4);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    action     <= act;
    word_lo    <= lo;
    word_hi    <= hi;
    do @(posedge clk); while (item_stall !== 1'b0);
    pending_hits.push_back(predict_hit(act, lo, hi));
  endtask

  // Holds items back until every expected result is in and the block is idle.
  task automatic drain_items();
    item_valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the size register; callers make sure the block is idle.
  task automatic write_size(input logic [4:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    size_now = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Inserts an item and remembers it for later queries.
  task automatic insert_item(input act_t act, input logic [63:0] lo, input logic [63:0] hi);
    inserted_t rec;
    rec.act = act;
    rec.lo  = lo;
    rec.hi  = hi;
    send_item(act, lo, hi);
    inserted_pool.push_back(rec);
    if (inserted_pool.size() > POOL_DEPTH) void'(inserted_pool.pop_front());
  endtask

  // Empty filter, extreme words, and both hash and key forms at the reset size.
  task automatic test_extremes();
    send_item(ACT_QRY_HASH, '0, '1);
    insert_item(ACT_INS_HASH, '0, '0);
    send_item(ACT_QRY_HASH, '0, '1);
    insert_item(ACT_INS_HASH, '1, '1);
    send_item(ACT_QRY_HASH, '1, '0);
    insert_item(ACT_INS_KEY, '1, '1);
    send_item(ACT_QRY_KEY, '1, '1);
    // A zero key folds to a zero hash, which is already in the filter.
    send_item(ACT_QRY_KEY, '0, '0);
    send_item(ACT_QRY_KEY, 64'd1, '1);
  endtask

  // Sizes below the minimum and above the maximum act as the nearest limit.
  task automatic test_size_clamping();
    drain_items();
    write_size(5'd0);
    insert_item(ACT_INS_HASH, 64'h0123_4567_89ab_cdef, '0);
    send_item(ACT_QRY_HASH, 64'hfedc_ba98_7654_3210, '0);
    drain_items();
    write_size(5'd5);
    send_item(ACT_QRY_HASH, 64'h0123_4567_89ab_cdef, '1);
    drain_items();
    write_size(5'd31);
    insert_item(ACT_INS_KEY, 64'h8000_0000_0000_0001, 64'h7fff_ffff_ffff_fffe);
    send_item(ACT_QRY_KEY, 64'h8000_0000_0000_0001, 64'h7fff_ffff_ffff_fffe);
    drain_items();
    write_size(5'd17);
    send_item(ACT_QRY_HASH, 64'h0123_4567_89ab_cdef, '0);
  endtask

  // Shrinking the size keeps the bits; growing it back finds earlier inserts again.
  task automatic test_size_change_keeps_bits();
    drain_items();
    write_size(5'd16);
    insert_item(ACT_INS_KEY, 64'h5555_aaaa_3333_cccc, 64'h0f0f_f0f0_1234_5678);
    drain_items();
    write_size(5'd8);
    send_item(ACT_QRY_KEY, 64'h5555_aaaa_3333_cccc, 64'h0f0f_f0f0_1234_5678);
    insert_item(ACT_INS_HASH, 64'hdead_beef_0000_ffff, '0);
    drain_items();
    write_size(5'd16);
    send_item(ACT_QRY_KEY, 64'h5555_aaaa_3333_cccc, 64'h0f0f_f0f0_1234_5678);
  endtask

  // One random item: mostly inserts and queries of earlier inserts, the rest noise.
  task automatic random_item();
    int        r;
    inserted_t rec;
    r = $urandom_range(99);
    if (r < 35 || inserted_pool.size() == 0) begin
      insert_item($urandom_range(1) ? ACT_INS_KEY : ACT_INS_HASH, rand_word(), rand_word());
    end else if (r < 75) begin
      rec = inserted_pool[$urandom_range(inserted_pool.size() - 1)];
      // The high word is ignored for hash items, so it is free to change.
      if (rec.act == ACT_INS_KEY) send_item(ACT_QRY_KEY, rec.lo, rec.hi);
      else send_item(ACT_QRY_HASH, rec.lo, rand_word());
    end else begin
      send_item(act_t'($urandom_range(3)), rand_word(), rand_word());
    end
  endtask

  // A run of random items under one size and one idling pattern.
  task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                   input logic [4:0] size, input int count);
    drain_items();
    write_size(size);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      random_item();
      if (n % 97 == 96) drain_items();
    end
  endtask

  // Receiver stalls at the rate that the current phase sets.
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Each accepted result is checked against the oldest expected hit.
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual hit %b", $time, hit);
        error_count++;
      end else if (hit !== pending_hits[0]) begin
        $display("%0t: hit mismatch, expected %b, actual %b", $time, pending_hits[0], hit);
        error_count++;
        void'(pending_hits.pop_front());
      end else begin
        void'(pending_hits.pop_front());
      end
    end
  end

  // Main sequence.
  initial begin
    foreach (filter_words[i]) filter_words[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_size_clamping();
    test_size_change_keeps_bits();
    test_random_phase(0, 0, 5'd16, 420);
    test_random_phase(58, 0, 5'd10, 420);
    test_random_phase(0, 58, 5'd7, 420);
    test_random_phase(7, 7, 5'd13, 420);
    drain_items();
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

[bloom_filter_double_hash.f]
design/bfdh_pkg.sv
design/bloom_filter_double_hash.sv
tb/tb.sv
